/* design/integer_calculator_alu_defines.svh */
// Assertion macros used by the checker file
`ifndef INTEGER_CALCULATOR_ALU_DEFINES_SVH
`define INTEGER_CALCULATOR_ALU_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle
`define ICA_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Assert that a condition implies a consequence in the next cycle
`define ICA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* design/ica_pkg.sv */
// Package: types, opcodes and sequencer states of the integer calculator
`timescale 1ns / 1ps
package ica_pkg;
	localparam int unsigned DataWidthDefault = 32;
	localparam int unsigned FieldWidth = 32;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_REM  = 3'd4,
		OP_GCD  = 3'd5,
		OP_POW  = 3'd6,
		OP_SQRT = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]            op;
		logic signed [FieldWidth-1:0] operand_a;
		logic signed [FieldWidth-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [FieldWidth-1:0] result_value;
		logic                         error_flag;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_WAIT,
		ST_DIV_RUN,
		ST_SQRT_RUN,
		ST_UNIT_END,
		ST_GCD_RUN,
		ST_GCD_STEP,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_POW_NEXT,
		ST_DONE
	} state_t;

	// Requests from the sequencer to the shared unit
	typedef enum logic [2:0] {
		U_NONE,
		U_DIV_INIT,
		U_DIV_STEP,
		U_SQRT_INIT,
		U_SQRT_STEP
	} ucmd_t;
endpackage

/* design/ica_mul.sv */
// Registered multiplier shared by mul and pow
`timescale 1ns / 1ps
module ica_mul #(
	parameter int unsigned DATA_WIDTH = ica_pkg::DataWidthDefault
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic [DATA_WIDTH-1:0] p
);
	localparam int unsigned HalfW = DATA_WIDTH / 2;
	localparam int unsigned HiW = DATA_WIDTH - HalfW;
	logic [DATA_WIDTH-1:0] ll_q, lh_q, hl_q;
	logic [HalfW-1:0] xl, yl;
	logic [HiW-1:0] xh, yh;

	assign xl = x[HalfW-1:0];
	assign yl = y[HalfW-1:0];
	assign xh = x[DATA_WIDTH-1:HalfW];
	assign yh = y[DATA_WIDTH-1:HalfW];

	// Partial products; the high by high product falls off the kept width
	always_ff @(posedge clk) begin
		ll_q <= DATA_WIDTH'({HalfW'(0), xl} * {HalfW'(0), yl});
		lh_q <= DATA_WIDTH'(xl * DATA_WIDTH'(yh));
		hl_q <= DATA_WIDTH'(xh * DATA_WIDTH'(yl));
	end

	assign p = ll_q + DATA_WIDTH'((lh_q + hl_q) << HalfW);
endmodule

/* design/ica_unit.sv */
// Shared restoring divide and square-root step unit
`timescale 1ns / 1ps
module ica_unit #(
	parameter int unsigned DATA_WIDTH = ica_pkg::DataWidthDefault
) (
	input  logic                  clk,
	input  ica_pkg::ucmd_t        cmd,
	input  logic [DATA_WIDTH-1:0] num,
	input  logic [DATA_WIDTH-1:0] den,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem,
	output logic                  last
);
	localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);
	localparam bit OddW = (DATA_WIDTH % 2 == 1);
	logic [DATA_WIDTH-1:0] q_q, n_q, d_q;
	logic [DATA_WIDTH:0]   r_q;
	logic [CntW-1:0]       cnt_q;
	logic [DATA_WIDTH:0]   shifted, trial;
	logic [DATA_WIDTH+1:0] sq_rem, sq_trial;
	logic                  ge;

	// Division: shift one dividend bit in, one compare-subtract per cycle.
	// Square root: two radicand bits in, trial is 4*root+1.
	assign shifted  = {r_q[DATA_WIDTH-1:0], n_q[DATA_WIDTH-1]};
	assign trial    = shifted - {1'b0, d_q};
	assign sq_rem   = {r_q[DATA_WIDTH-1:0], n_q[DATA_WIDTH-1:DATA_WIDTH-2]};
	assign sq_trial = {q_q, 2'b01};
	assign ge = (cmd == ica_pkg::U_SQRT_STEP) ? (sq_rem >= sq_trial) : !trial[DATA_WIDTH];

	always_ff @(posedge clk) begin
		unique case (cmd)
			ica_pkg::U_DIV_INIT: begin
				q_q <= '0; r_q <= '0; n_q <= num; d_q <= den;
				cnt_q <= CntW'(DATA_WIDTH - 1);
			end
			ica_pkg::U_DIV_STEP: begin
				n_q <= n_q << 1;
				q_q <= {q_q[DATA_WIDTH-2:0], ge};
				r_q <= ge ? trial : shifted;
				cnt_q <= cnt_q - 1'b1;
			end
			ica_pkg::U_SQRT_INIT: begin
				// Odd width: drop the clear sign bit so the bit pairs line up
				q_q <= '0; r_q <= '0; n_q <= OddW ? (num << 1) : num; d_q <= den;
				cnt_q <= CntW'(DATA_WIDTH / 2 - 1);
			end
			ica_pkg::U_SQRT_STEP: begin
				n_q <= n_q << 2;
				q_q <= {q_q[DATA_WIDTH-2:0], ge};
				r_q <= ge ? (DATA_WIDTH+1)'(sq_rem - sq_trial) : (DATA_WIDTH+1)'(sq_rem);
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign quo  = q_q;
	assign rem  = r_q[DATA_WIDTH-1:0];
	assign last = (cnt_q == '0);
endmodule

/* design/integer_calculator_alu.sv */
// Top level of the integer calculator: sequencer, operand registers, result
//
//  channel  | signals                         | handshake
//  request  | start, busy, req (op, operands) | taken when start && !busy
//  response | rsp_valid, rsp (value, flag)    | one-cycle strobe, no stall
//
// busy rises at the accepting edge and stays high through the strobe cycle.
// Add, sub and the early exits (zero divisor, negative radicand, gcd with a
// zero second operand, exponent of zero or less) go from load to done; mul
// waits for the product; div, rem and sqrt step the shared unit; pow passes
// multiply, square and next states per exponent bit; gcd runs a division per
// Euclid step. Reset clears the sequencer; results cannot stall.
`timescale 1ns / 1ps
module integer_calculator_alu #(
	parameter int unsigned DATA_WIDTH = ica_pkg::DataWidthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ica_pkg::req_t req,
	output logic          rsp_valid,
	output ica_pkg::rsp_t rsp
);
	localparam int unsigned W = DATA_WIDTH;
	localparam int unsigned FW = ica_pkg::FieldWidth;

	ica_pkg::state_t state_q, state_d, route;
	ica_pkg::ucmd_t  ucmd;
	ica_pkg::op_t    op_q;
	logic [W-1:0]  a_q, b_q, y_q, acc_q, base_q, e_q, res_q;
	logic          err_q;
	logic [W-1:0]  a_ext, b_ext, ma, mb, quo, rem, prod, mx, my, unum, uden;
	logic          last;
	logic [FW-1:0] rsp_value;

	// Sign-extend or truncate each field to the working width
	function automatic logic [W-1:0] ext(input logic [FW-1:0] v);
		logic [W+FW-1:0] t;
		t = {{W{v[FW-1]}}, v};
		return t[W-1:0];
	endfunction

	// Zero-extend or truncate the working value to the field width
	function automatic logic [FW-1:0] to_field(input logic [W-1:0] v);
		logic [W+FW-1:0] t;
		t = {{FW{1'b0}}, v};
		return t[FW-1:0];
	endfunction

	assign a_ext = ext(req.operand_a);
	assign b_ext = ext(req.operand_b);
	assign ma = a_q[W-1] ? W'(-a_q) : a_q;
	assign mb = b_q[W-1] ? W'(-b_q) : b_q;

	assign mx = (state_q == ica_pkg::ST_POW_MUL) ? acc_q
		: ((state_q == ica_pkg::ST_POW_SQR) ? base_q : a_q);
	assign my = (state_q == ica_pkg::ST_POW_MUL || state_q == ica_pkg::ST_POW_SQR)
		? base_q : b_q;

	ica_mul #(.DATA_WIDTH(W)) u_mul (.clk(clk), .x(mx), .y(my), .p(prod));

	// Each further Euclid step divides the old divisor by the remainder
	assign unum = (state_q == ica_pkg::ST_GCD_STEP) ? y_q : ma;
	assign uden = (state_q == ica_pkg::ST_GCD_STEP) ? rem : mb;

	ica_unit #(.DATA_WIDTH(W)) u_unit (
		.clk(clk), .cmd(ucmd), .num(unum), .den(uden),
		.quo(quo), .rem(rem), .last(last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ica_pkg::ST_IDLE;
			op_q <= ica_pkg::OP_ADD;
		end else begin
			state_q <= state_d;
			if (state_q == ica_pkg::ST_IDLE && start) begin
				op_q <= ica_pkg::op_t'(req.op);
			end
		end
	end

	// Per-op routing once the operands are held
	always_comb begin
		unique case (op_q)
			ica_pkg::OP_ADD, ica_pkg::OP_SUB: route = ica_pkg::ST_DONE;
			ica_pkg::OP_MUL: route = ica_pkg::ST_MUL_WAIT;
			ica_pkg::OP_DIV, ica_pkg::OP_REM:
				route = (mb == '0) ? ica_pkg::ST_DONE : ica_pkg::ST_DIV_RUN;
			ica_pkg::OP_GCD:
				route = (mb == '0) ? ica_pkg::ST_DONE : ica_pkg::ST_GCD_RUN;
			ica_pkg::OP_POW:
				route = (b_q[W-1] || b_q == '0) ? ica_pkg::ST_DONE : ica_pkg::ST_POW_MUL;
			ica_pkg::OP_SQRT: route = a_q[W-1] ? ica_pkg::ST_DONE : ica_pkg::ST_SQRT_RUN;
			default: route = ica_pkg::ST_DONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ucmd = ica_pkg::U_NONE;
		unique case (state_q)
			ica_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ica_pkg::ST_LOAD;
				end
			end
			ica_pkg::ST_LOAD: begin
				state_d = route;
				if (route == ica_pkg::ST_SQRT_RUN) begin
					ucmd = ica_pkg::U_SQRT_INIT;
				end else if (route == ica_pkg::ST_DIV_RUN || route == ica_pkg::ST_GCD_RUN) begin
					ucmd = ica_pkg::U_DIV_INIT;
				end
			end
			ica_pkg::ST_MUL_WAIT: state_d = ica_pkg::ST_DONE;
			ica_pkg::ST_DIV_RUN: begin
				ucmd = ica_pkg::U_DIV_STEP;
				if (last) begin
					state_d = ica_pkg::ST_UNIT_END;
				end
			end
			ica_pkg::ST_SQRT_RUN: begin
				ucmd = ica_pkg::U_SQRT_STEP;
				if (last) begin
					state_d = ica_pkg::ST_UNIT_END;
				end
			end
			ica_pkg::ST_UNIT_END: state_d = ica_pkg::ST_DONE;
			ica_pkg::ST_GCD_RUN: begin
				ucmd = ica_pkg::U_DIV_STEP;
				if (last) begin
					state_d = ica_pkg::ST_GCD_STEP;
				end
			end
			ica_pkg::ST_GCD_STEP: begin
				if (rem == '0) begin
					state_d = ica_pkg::ST_DONE;
				end else begin
					ucmd = ica_pkg::U_DIV_INIT;
					state_d = ica_pkg::ST_GCD_RUN;
				end
			end
			ica_pkg::ST_POW_MUL: state_d = ica_pkg::ST_POW_SQR;
			ica_pkg::ST_POW_SQR: state_d = ica_pkg::ST_POW_NEXT;
			ica_pkg::ST_POW_NEXT: begin
				state_d = (e_q[W-1:1] == '0) ? ica_pkg::ST_DONE : ica_pkg::ST_POW_MUL;
			end
			ica_pkg::ST_DONE: state_d = ica_pkg::ST_IDLE;
			default: state_d = ica_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers; the multiplier product lands in the cycle after its operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			ica_pkg::ST_IDLE: begin
				if (start) begin
					a_q <= a_ext;
					b_q <= b_ext;
				end
			end
			ica_pkg::ST_LOAD: begin
				err_q <= 1'b0;
				y_q <= mb;
				acc_q <= W'(1);
				base_q <= a_q;
				e_q <= b_q;
				unique case (op_q)
					ica_pkg::OP_ADD: res_q <= a_q + b_q;
					ica_pkg::OP_SUB: res_q <= a_q - b_q;
					ica_pkg::OP_DIV, ica_pkg::OP_REM: begin
						err_q <= (mb == '0);
						res_q <= '0;
					end
					ica_pkg::OP_GCD: begin
						err_q <= (ma == '0) && (mb == '0);
						res_q <= ma;
					end
					ica_pkg::OP_POW: res_q <= W'(1);
					ica_pkg::OP_SQRT: begin
						err_q <= a_q[W-1];
						res_q <= '0;
					end
					default: res_q <= '0;
				endcase
			end
			ica_pkg::ST_MUL_WAIT: res_q <= prod;
			ica_pkg::ST_UNIT_END: begin
				unique case (op_q)
					ica_pkg::OP_DIV: res_q <= (a_q[W-1] ^ b_q[W-1]) ? W'(-quo) : quo;
					ica_pkg::OP_REM: res_q <= a_q[W-1] ? W'(-rem) : rem;
					default: res_q <= quo;
				endcase
			end
			ica_pkg::ST_GCD_STEP: begin
				y_q <= rem;
				if (rem == '0) begin
					res_q <= y_q;
				end
			end
			ica_pkg::ST_POW_SQR: begin
				if (e_q[0]) begin
					acc_q <= prod;
				end
			end
			ica_pkg::ST_POW_NEXT: begin
				base_q <= prod;
				e_q <= e_q >> 1;
				res_q <= acc_q;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ica_pkg::ST_IDLE);
	assign rsp_valid = (state_q == ica_pkg::ST_DONE);
	assign rsp_value = err_q ? '0 : to_field(res_q);
	assign rsp = '{result_value: rsp_value, error_flag: err_q};
endmodule

/* design/ica_checker.sv */
// Port-level checker for the integer calculator, bound to the top level
`timescale 1ns / 1ps
`include "integer_calculator_alu_defines.svh"
module ica_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          rsp_valid,
	input ica_pkg::rsp_t rsp
);
	logic flagged_rsp, zero_value;

	assign flagged_rsp = rsp_valid && rsp.error_flag;
	assign zero_value = (rsp.result_value == '0);

	`ICA_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "no busy after start")
	`ICA_ASSERT_SAME(a_err_zero, clk, arst_n, flagged_rsp, zero_value, "error result not zero")
	`ICA_ASSERT_NEXT(a_strobe_once, clk, arst_n, rsp_valid, !rsp_valid, "result strobe held")
	`ICA_ASSERT_SAME(a_strobe_busy, clk, arst_n, rsp_valid, busy, "result strobe while idle")
endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.rsp_valid(rsp_valid), .rsp(rsp)
);
